@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FADD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define FADD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FADD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define FADD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/fadd_pkg.sv @@
// ----------------------------------------------------------------------------
// fraction add and reduce package
// widths, state types and status struct shared by the core and its reducer
// ----------------------------------------------------------------------------
package fadd_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int MAG_BITS     = OPERAND_BITS - 1;
    localparam int PROD_BITS    = 2 * MAG_BITS;
    localparam int DATA_BITS    = 2 * MAG_BITS + 1;
    localparam int NUM_BITS     = 31;
    localparam int DEN_BITS     = 30;
    localparam int SHIFT_BITS   = $clog2(DATA_BITS);
    localparam int COUNT_BITS   = $clog2(DATA_BITS);

    typedef enum logic [3:0] {
        T_IDLE,
        T_CHECK,
        T_RED_L,
        T_RED_R,
        T_MUL_DEN,
        T_MUL_AN,
        T_MUL_CN,
        T_SUM,
        T_RED_S,
        T_FIN
    } top_state_t;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_GCD,
        RD_DIV_NUM,
        RD_DIV_DEN
    } red_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } red_status_t;

endpackage

@@ sv/fadd_reduce.sv @@
// ----------------------------------------------------------------------------
// fraction reducer
// binary gcd followed by two restoring divisions, all on one shared subtractor
// ----------------------------------------------------------------------------
module fadd_reduce import fadd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DATA_BITS-1:0] num_in,
    input  logic [DATA_BITS-1:0] den_in,
    output red_status_t          status,
    output logic [DATA_BITS-1:0] num_out,
    output logic [DATA_BITS-1:0] den_out
);

    red_state_t               state_reg, state_next;
    logic                     done_reg, done_next;
    logic [DATA_BITS-1:0]     num_reg, num_next;
    logic [DATA_BITS-1:0]     den_reg, den_next;
    logic [DATA_BITS-1:0]     u_reg, u_next;
    logic [DATA_BITS-1:0]     v_reg, v_next;
    logic [SHIFT_BITS-1:0]    k_reg, k_next;
    logic [DATA_BITS-1:0]     g_reg, g_next;
    logic [DATA_BITS-1:0]     rem_reg, rem_next;
    logic [DATA_BITS-1:0]     quo_reg, quo_next;
    logic [COUNT_BITS-1:0]    cnt_reg, cnt_next;

    logic [DATA_BITS:0]       trial;
    logic [DATA_BITS:0]       sub_a;
    logic [DATA_BITS:0]       sub_b;
    logic [DATA_BITS+1:0]     sub_full;
    logic [DATA_BITS:0]       sub_diff;
    logic                     sub_borrow;
    logic [DATA_BITS-1:0]     quo_shift;

    // shared subtractor
    assign trial      = {rem_reg, quo_reg[DATA_BITS-1]};
    assign sub_full   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_diff   = sub_full[DATA_BITS:0];
    assign sub_borrow = sub_full[DATA_BITS+1];
    assign quo_shift  = {quo_reg[DATA_BITS-2:0], ~sub_borrow};

    always_comb
    begin
        if (state_reg == RD_GCD)
        begin
            sub_a = {1'b0, u_reg};
            sub_b = {1'b0, v_reg};
        end
        else
        begin
            sub_a = trial;
            sub_b = {1'b0, g_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        den_next   = den_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            RD_IDLE:
            begin
                if (start)
                begin
                    num_next = num_in;
                    den_next = den_in;
                    if ((num_in == '0) || (den_in == '0))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        u_next     = num_in;
                        v_next     = den_in;
                        k_next     = '0;
                        state_next = RD_GCD;
                    end
                end
            end
            RD_GCD:
            begin
                if (u_reg == v_reg)
                begin
                    g_next     = u_reg << k_reg;
                    quo_next   = num_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = RD_DIV_NUM;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (!sub_borrow)
                begin
                    u_next = sub_diff[DATA_BITS-1:0];
                end
                else
                begin
                    // keep the larger value in u
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            RD_DIV_NUM, RD_DIV_DEN:
            begin
                rem_next = sub_borrow ? trial[DATA_BITS-1:0] : sub_diff[DATA_BITS-1:0];
                quo_next = quo_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == COUNT_BITS'(DATA_BITS - 1))
                begin
                    rem_next = '0;
                    cnt_next = '0;
                    if (state_reg == RD_DIV_NUM)
                    begin
                        num_next   = quo_shift;
                        quo_next   = den_reg;
                        state_next = RD_DIV_DEN;
                    end
                    else
                    begin
                        den_next   = quo_shift;
                        done_next  = 1'b1;
                        state_next = RD_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = RD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        k_reg   <= k_next;
        g_reg   <= g_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign status.busy = (state_reg != RD_IDLE);
    assign status.done = done_reg;
    assign num_out     = num_reg;
    assign den_out     = den_reg;

endmodule

@@ sv/fraction_add_reduce_core.sv @@
// ----------------------------------------------------------------------------
// fraction add and reduce core
// normalizes one fraction or adds two, giving the result in lowest terms
// ----------------------------------------------------------------------------
// One item is in work at a time; req_stall stays high from the transfer of an
// item until its result is loaded into the output register. Every reduction
// runs on the one subtractor inside fadd_reduce: binary gcd steps over the
// 31-bit datapath and then two restoring divisions. A normalize is one
// reduction; an add is three reductions plus the products on a single 15x15
// multiplier and their sum. An empty item skips all reductions, and a zero
// numerator skips the gcd and the divisions of that reduction. A result
// waiting in the output register does not block the next item's work.
`include "assert_macros.svh"

module fraction_add_reduce_core import fadd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           operation,
    input  logic signed [OPERAND_BITS-1:0] lhs_num,
    input  logic signed [OPERAND_BITS-1:0] lhs_den,
    input  logic signed [OPERAND_BITS-1:0] rhs_num,
    input  logic signed [OPERAND_BITS-1:0] rhs_den,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [NUM_BITS-1:0]            sum_num,
    output logic [DEN_BITS-1:0]            sum_den,
    output logic                           is_empty
);

    top_state_t            state_reg, state_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  add_reg, add_next;
    logic                  lv_reg, lv_next;
    logic                  rv_reg, rv_next;
    logic                  empty_reg, empty_next;
    logic [MAG_BITS-1:0]   an_reg, an_next;
    logic [MAG_BITS-1:0]   ad_reg, ad_next;
    logic [MAG_BITS-1:0]   cn_reg, cn_next;
    logic [MAG_BITS-1:0]   cd_reg, cd_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [DATA_BITS-1:0]  acc_num_reg, acc_num_next;
    logic [DATA_BITS-1:0]  acc_den_reg, acc_den_next;
    logic [NUM_BITS-1:0]   sum_num_reg, sum_num_next;
    logic [DEN_BITS-1:0]   sum_den_reg, sum_den_next;
    logic                  is_empty_reg, is_empty_next;

    logic [MAG_BITS-1:0]   mul_a;
    logic [MAG_BITS-1:0]   mul_b;
    logic [PROD_BITS-1:0]  mul_p;

    logic                  red_start;
    logic [DATA_BITS-1:0]  red_num_in;
    logic [DATA_BITS-1:0]  red_den_in;
    red_status_t           red_status;
    logic [DATA_BITS-1:0]  red_num_out;
    logic [DATA_BITS-1:0]  red_den_out;

    fadd_reduce u_reduce
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .num_in  (red_num_in),
        .den_in  (red_den_in),
        .status  (red_status),
        .num_out (red_num_out),
        .den_out (red_den_out)
    );

    assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        add_next       = add_reg;
        lv_next        = lv_reg;
        rv_next        = rv_reg;
        empty_next     = empty_reg;
        an_next        = an_reg;
        ad_next        = ad_reg;
        cn_next        = cn_reg;
        cd_next        = cd_reg;
        prod_next      = prod_reg;
        acc_num_next   = acc_num_reg;
        acc_den_next   = acc_den_reg;
        sum_num_next   = sum_num_reg;
        sum_den_next   = sum_den_reg;
        is_empty_next  = is_empty_reg;
        mul_a          = ad_reg;
        mul_b          = cd_reg;
        red_start      = 1'b0;
        red_num_in     = DATA_BITS'(an_reg);
        red_den_in     = DATA_BITS'(ad_reg);

        // output transfer frees the result register
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            T_IDLE:
            begin
                if (req_valid)
                begin
                    add_next   = operation;
                    an_next    = lhs_num[MAG_BITS-1:0];
                    ad_next    = lhs_den[MAG_BITS-1:0];
                    cn_next    = rhs_num[MAG_BITS-1:0];
                    cd_next    = rhs_den[MAG_BITS-1:0];
                    lv_next    = !lhs_num[OPERAND_BITS-1] && !lhs_den[OPERAND_BITS-1]
                                 && (lhs_den[MAG_BITS-1:0] != '0);
                    rv_next    = !rhs_num[OPERAND_BITS-1] && !rhs_den[OPERAND_BITS-1]
                                 && (rhs_den[MAG_BITS-1:0] != '0);
                    state_next = T_CHECK;
                end
            end
            T_CHECK:
            begin
                if (!lv_reg || (add_reg && !rv_reg))
                begin
                    empty_next   = 1'b1;
                    acc_num_next = '0;
                    acc_den_next = '0;
                    state_next   = T_FIN;
                end
                else
                begin
                    empty_next = 1'b0;
                    red_start  = 1'b1;
                    state_next = T_RED_L;
                end
            end
            T_RED_L:
            begin
                if (red_status.done)
                begin
                    an_next = red_num_out[MAG_BITS-1:0];
                    ad_next = red_den_out[MAG_BITS-1:0];
                    if (add_reg)
                    begin
                        red_start  = 1'b1;
                        red_num_in = DATA_BITS'(cn_reg);
                        red_den_in = DATA_BITS'(cd_reg);
                        state_next = T_RED_R;
                    end
                    else
                    begin
                        acc_num_next = red_num_out;
                        acc_den_next = red_den_out;
                        state_next   = T_FIN;
                    end
                end
            end
            T_RED_R:
            begin
                if (red_status.done)
                begin
                    cn_next    = red_num_out[MAG_BITS-1:0];
                    cd_next    = red_den_out[MAG_BITS-1:0];
                    state_next = T_MUL_DEN;
                end
            end
            T_MUL_DEN:
            begin
                prod_next  = mul_p;
                state_next = T_MUL_AN;
            end
            T_MUL_AN:
            begin
                mul_a        = an_reg;
                mul_b        = cd_reg;
                prod_next    = mul_p;
                acc_den_next = DATA_BITS'(prod_reg);
                state_next   = T_MUL_CN;
            end
            T_MUL_CN:
            begin
                mul_a        = ad_reg;
                mul_b        = cn_reg;
                prod_next    = mul_p;
                acc_num_next = DATA_BITS'(prod_reg);
                state_next   = T_SUM;
            end
            T_SUM:
            begin
                red_start  = 1'b1;
                red_num_in = acc_num_reg + DATA_BITS'(prod_reg);
                red_den_in = acc_den_reg;
                state_next = T_RED_S;
            end
            T_RED_S:
            begin
                if (red_status.done)
                begin
                    acc_num_next = red_num_out;
                    acc_den_next = red_den_out;
                    state_next   = T_FIN;
                end
            end
            T_FIN:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    sum_num_next   = NUM_BITS'(acc_num_reg);
                    sum_den_next   = DEN_BITS'(acc_den_reg);
                    is_empty_next  = empty_reg;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_reg      <= add_next;
        lv_reg       <= lv_next;
        rv_reg       <= rv_next;
        empty_reg    <= empty_next;
        an_reg       <= an_next;
        ad_reg       <= ad_next;
        cn_reg       <= cn_next;
        cd_reg       <= cd_next;
        prod_reg     <= prod_next;
        acc_num_reg  <= acc_num_next;
        acc_den_reg  <= acc_den_next;
        sum_num_reg  <= sum_num_next;
        sum_den_reg  <= sum_den_next;
        is_empty_reg <= is_empty_next;
    end

    assign req_stall = (state_reg != T_IDLE);
    assign res_valid = res_valid_reg;
    assign sum_num   = sum_num_reg;
    assign sum_den   = sum_den_reg;
    assign is_empty  = is_empty_reg;

    // reducer is only started when free, and it then reports busy or done
    `FADD_ASSERT_IMPLIES(a_start_idle, clk, rst_n, red_start, !red_status.busy)
    `FADD_ASSERT_NEXT(a_start_takes, clk, rst_n, red_start, red_status.busy || red_status.done)
    // empty results carry 0/0, others a nonzero denominator
    `FADD_ASSERT_IMPLIES(a_empty_zero, clk, rst_n, res_valid && is_empty, {sum_num, sum_den} == '0)
    `FADD_ASSERT_IMPLIES(a_den_nonzero, clk, rst_n, res_valid && !is_empty, sum_den != '0)

endmodule

@@ tb/sv/fraction_add_reduce_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction add and reduce core testbench
// drives normalize and add requests with bursty valid and a patterned result
// stall, predicts each reduced fraction and checks every transfer in order
// ----------------------------------------------------------------------------
module fraction_add_reduce_core_tb import fadd_pkg::*;
;

    localparam logic OP_NORMALIZE = 1'b0;
    localparam logic OP_ADD       = 1'b1;
    localparam int   MAG_MAX      = (1 << MAG_BITS) - 1;
    localparam int   RANDOM_ITEMS = 1000;
    localparam int   HOLD_LEN     = 2500;
    localparam int   HOLD_AFTER   = 300;
    localparam int   SETTLE_LEN   = 600;
    localparam int   CYCLE_LIMIT  = 4000000;

    typedef struct {
        logic                    operation;
        logic [OPERAND_BITS-1:0] lhs_num;
        logic [OPERAND_BITS-1:0] lhs_den;
        logic [OPERAND_BITS-1:0] rhs_num;
        logic [OPERAND_BITS-1:0] rhs_den;
    } frac_item_t;

    typedef struct {
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
        logic                empty;
    } frac_sum_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           req_valid = 1'b0;
    logic                           req_stall;
    logic                           operation = OP_NORMALIZE;
    logic signed [OPERAND_BITS-1:0] lhs_num   = '0;
    logic signed [OPERAND_BITS-1:0] lhs_den   = '0;
    logic signed [OPERAND_BITS-1:0] rhs_num   = '0;
    logic signed [OPERAND_BITS-1:0] rhs_den   = '0;
    logic                           res_valid;
    logic                           res_stall = 1'b0;
    logic [NUM_BITS-1:0]            sum_num;
    logic [DEN_BITS-1:0]            sum_den;
    logic                           is_empty;

    frac_item_t  request_queue[$];
    frac_sum_t   sums_due[$];
    frac_item_t  next_request;
    frac_item_t  seen_request;
    frac_sum_t   due_sum;
    logic        req_fire      = 1'b0;
    int unsigned burst_left    = 0;
    int unsigned gap_left      = 0;
    int unsigned stall_seg     = 0;
    int unsigned stall_pct     = 0;
    int unsigned results_seen  = 0;
    int unsigned hold_cycles   = 0;
    logic        hold_active   = 1'b0;
    logic        hold_done     = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;

    fraction_add_reduce_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .lhs_num   (lhs_num),
        .lhs_den   (lhs_den),
        .rhs_num   (rhs_num),
        .rhs_den   (rhs_den),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sum_num   (sum_num),
        .sum_den   (sum_den),
        .is_empty  (is_empty)
    );

    always #6 clk = ~clk;

    // lowest terms, zero numerator left alone
    function automatic void reduce_terms(inout longint unsigned n, inout longint unsigned d);
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        if (n == 0 || d == 0)
        begin
            return;
        end
        x = n;
        y = d;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        n = n / x;
        d = d / x;
    endfunction

    function automatic logic load_fraction(input logic [OPERAND_BITS-1:0] raw_n,
                                           input logic [OPERAND_BITS-1:0] raw_d,
                                           output longint unsigned n,
                                           output longint unsigned d);
        n = 0;
        d = 0;
        if (raw_n[OPERAND_BITS-1] || raw_d[OPERAND_BITS-1] || raw_d == '0)
        begin
            return 1'b0;
        end
        n = 64'(raw_n[MAG_BITS-1:0]);
        d = 64'(raw_d[MAG_BITS-1:0]);
        reduce_terms(n, d);
        return 1'b1;
    endfunction

    function automatic frac_sum_t reduced_sum(frac_item_t it);
        longint unsigned an;
        longint unsigned ad;
        longint unsigned cn;
        longint unsigned cd;
        longint unsigned rn;
        longint unsigned rd;
        logic            lhs_ok;
        logic            rhs_ok;
        frac_sum_t       r;
        lhs_ok = load_fraction(it.lhs_num, it.lhs_den, an, ad);
        rhs_ok = load_fraction(it.rhs_num, it.rhs_den, cn, cd);
        rn = 0;
        rd = 0;
        if (it.operation == OP_NORMALIZE)
        begin
            r.empty = !lhs_ok;
            rn = an;
            rd = ad;
        end
        else
        begin
            r.empty = !(lhs_ok && rhs_ok);
            rd = ad * cd;
            rn = an * cd + ad * cn;
            reduce_terms(rn, rd);
        end
        r.num = r.empty ? '0 : rn[NUM_BITS-1:0];
        r.den = r.empty ? '0 : rd[DEN_BITS-1:0];
        return r;
    endfunction

    function automatic void push_request(logic op, int ln, int ld, int rn, int rd);
        frac_item_t it;
        it.operation = op;
        it.lhs_num   = ln[OPERAND_BITS-1:0];
        it.lhs_den   = ld[OPERAND_BITS-1:0];
        it.rhs_num   = rn[OPERAND_BITS-1:0];
        it.rhs_den   = rd[OPERAND_BITS-1:0];
        request_queue.push_back(it);
    endfunction

    // mostly well-formed fractions with shared factors, some raw noise
    function automatic void make_fraction(output logic [OPERAND_BITS-1:0] n,
                                          output logic [OPERAND_BITS-1:0] d);
        int unsigned kind;
        int unsigned g;
        int unsigned lim;
        kind = $urandom_range(0, 99);
        g = 1;
        if (kind < 8)
        begin
            n = OPERAND_BITS'($urandom);
            d = OPERAND_BITS'($urandom);
        end
        else if (kind < 11)
        begin
            n = OPERAND_BITS'($urandom_range(0, MAG_MAX));
            d = '0;
        end
        else
        begin
            if (kind >= 40)
            begin
                g = (kind < 75) ? $urandom_range(2, 64) : $urandom_range(65, 4096);
            end
            lim = MAG_MAX / g;
            if (kind % 4 == 0 && lim > 24)
            begin
                lim = 24;
            end
            n = OPERAND_BITS'(g * $urandom_range(0, lim));
            d = OPERAND_BITS'(g * $urandom_range(1, lim));
            if ($urandom_range(0, 15) == 0)
            begin
                n = '0;
            end
        end
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (error_count < 40)
        begin
            $display("mismatch on result %0d: %s got %0d want %0d",
                     results_seen, what, got, want);
        end
        error_count++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left  <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (request_queue.size() != 0)
            begin
                next_request = request_queue.pop_front();
                operation <= next_request.operation;
                lhs_num   <= next_request.lhs_num;
                lhs_den   <= next_request.lhs_den;
                rhs_num   <= next_request.rhs_num;
                rhs_den   <= next_request.rhs_den;
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    case ($urandom_range(0, 19) / 7)
                        0: gap_left <= 0;
                        1: gap_left <= $urandom_range(1, 20);
                        default: gap_left <= $urandom_range(1, 19) < 7 ?
                                             $urandom_range(50, 500) : $urandom_range(1, 40);
                    endcase
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // result stall pattern
    always @(negedge clk)
    begin
        if (stall_seg == 0)
        begin
            stall_seg <= $urandom_range(5, 150);
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                2: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end
        else
        begin
            stall_seg <= stall_seg - 1;
        end
        res_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);
    end

    // one long hold-off on results so the core backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_active <= 1'b0;
            hold_done   <= 1'b0;
        end
        else if (hold_active)
        begin
            if (hold_cycles == HOLD_LEN - 1)
            begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
            hold_cycles <= hold_cycles + 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_active <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                seen_request.operation = operation;
                seen_request.lhs_num   = lhs_num;
                seen_request.lhs_den   = lhs_den;
                seen_request.rhs_num   = rhs_num;
                seen_request.rhs_den   = rhs_den;
                sums_due.push_back(reduced_sum(seen_request));
            end
            if (res_valid && !res_stall)
            begin
                if (sums_due.size() == 0)
                begin
                    report_mismatch("transfer with nothing due, sum_num", sum_num, 0);
                end
                else
                begin
                    due_sum = sums_due.pop_front();
                    if (sum_num !== due_sum.num)
                    begin
                        report_mismatch("sum_num", sum_num, due_sum.num);
                    end
                    if (sum_den !== due_sum.den)
                    begin
                        report_mismatch("sum_den", sum_den, due_sum.den);
                    end
                    if (is_empty !== due_sum.empty)
                    begin
                        report_mismatch("is_empty", is_empty, due_sum.empty);
                    end
                end
                results_seen <= results_seen + 1;
            end
        end
        req_fire <= rst_n && req_valid && !req_stall;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        frac_item_t it;

        push_request(OP_NORMALIZE, MAG_MAX, MAG_MAX, 0, 0);
        push_request(OP_NORMALIZE, 0, 6, 0, 0);
        push_request(OP_NORMALIZE, 12, 18, -32768, 0);
        push_request(OP_NORMALIZE, -1, 5, 3, 4);
        push_request(OP_NORMALIZE, 5, 0, 1, 1);
        push_request(OP_NORMALIZE, 5, -32768, 1, 1);
        push_request(OP_NORMALIZE, -32768, -1, -1, -1);
        push_request(OP_NORMALIZE, MAG_MAX, 1, MAG_MAX, MAG_MAX);
        push_request(OP_NORMALIZE, 1, MAG_MAX, 0, 1);
        push_request(OP_ADD, MAG_MAX, 1, MAG_MAX, 1);
        push_request(OP_ADD, MAG_MAX, MAG_MAX - 1, MAG_MAX - 1, MAG_MAX);
        push_request(OP_ADD, 1, MAG_MAX, 1, MAG_MAX);
        push_request(OP_ADD, 0, 6, 0, 4);
        push_request(OP_ADD, 0, 6, 1, 3);
        push_request(OP_ADD, 1, 2, 1, 2);
        push_request(OP_ADD, 6, 4, 3, 9);
        push_request(OP_ADD, 1, 3, -1, 3);
        push_request(OP_ADD, 1, 0, 1, 3);
        push_request(OP_ADD, 1, 3, 1, -3);
        push_request(OP_ADD, -32768, -32768, 0, 0);
        push_request(OP_ADD, 0, 1, 0, 1);
        push_request(OP_ADD, MAG_MAX, 1, 0, MAG_MAX);
        push_request(OP_ADD, 16384, 16384, 0, 1);
        push_request(OP_ADD, 4096, 12288, 21845, MAG_MAX);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            it.operation = 1'($urandom_range(0, 1));
            make_fraction(it.lhs_num, it.lhs_den);
            make_fraction(it.rhs_num, it.rhs_den);
            request_queue.push_back(it);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || req_valid || sums_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_LEN) @(posedge clk);

        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
